// ----- sv/clc_pkg.sv -----
// Shared types, register codes and the distance function for the leader clustering block.
// No dependencies; used by clc_cell and circular_leader_clustering.
package clc_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned RES_W   = 17;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam logic             MODE_RESET = 1'b1;
  localparam logic [RES_W-1:0] RES_RESET  = 17'd656;

  localparam logic [VALUE_W-1:0] HALF_CIRCLE = 16'd32768;
  localparam logic [RES_W-1:0]   FULL_CIRCLE = 17'h10000;

  // register select, taken from paddr[2]
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_RES  = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               found;
    logic               created;
  } tok_t;

  function automatic logic [RES_W-1:0] leader_distance(input logic [VALUE_W-1:0] a,
                                                       input logic [VALUE_W-1:0] b,
                                                       input logic circ);
    logic [VALUE_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    if (circ && (d > HALF_CIRCLE)) begin
      return FULL_CIRCLE - {1'b0, d};
    end
    return {1'b0, d};
  endfunction

endpackage

// ----- sv/clc_cell.sv -----
// One leader cell of the chain: holds one group leader and passes the request onward.
// Depends on clc_pkg (tok_t, leader_distance).
module clc_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        circular_mode_i,
  input  logic [clc_pkg::RES_W-1:0]   resolution_i,
  input  clc_pkg::tok_t               tok_i,
  input  logic [IDX_W-1:0]            idx_i,
  input  logic [CNT_W-1:0]            cnt_i,
  output clc_pkg::tok_t               tok_o,
  output logic [IDX_W-1:0]            idx_o,
  output logic [CNT_W-1:0]            cnt_o
);
  import clc_pkg::*;

  logic [VALUE_W-1:0] leader_q;
  tok_t               tok_q, tok_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               open_req;
  logic               occupied;
  logic               hit;
  logic               claim;
  logic [RES_W-1:0]   lead_gap;

  assign open_req = tok_i.valid & ~tok_i.found;
  assign occupied = CNT_W'(CELL_IDX) < cnt_i;
  assign lead_gap = leader_distance(leader_q, tok_i.value, circular_mode_i);
  assign hit      = open_req & occupied & (lead_gap < resolution_i);
  assign claim    = open_req & (cnt_i == CNT_W'(CELL_IDX));

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    cnt_d = cnt_i;
    priority if (hit) begin
      tok_d.found = 1'b1;
      idx_d       = IDX_W'(CELL_IDX);
    end else if (claim) begin
      tok_d.found   = 1'b1;
      tok_d.created = 1'b1;
      idx_d         = IDX_W'(CELL_IDX);
      cnt_d         = cnt_i + CNT_W'(1);
    end else begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    if (claim) begin
      leader_q <= tok_i.value;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;
  assign cnt_o = cnt_q;

endmodule

// ----- sv/circular_leader_clustering.sv -----
// An accepted request passes through the cell registers of the leader chain, then the done and output registers.
// Only one request is in flight at a time: the request walks the leader chain,
// one cell per cycle, and the next is taken once its result reaches the output register.
// Reset: empties the group table, sets circular_mode to 1 and resolution to 656.
// Depends on clc_pkg and clc_cell.
module circular_leader_clustering #(
  parameter int unsigned NUM_LEADERS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clc_pkg::ADDR_W-1:0]    paddr,
  input  logic [clc_pkg::DATA_W-1:0]    pwdata,
  output logic [clc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [clc_pkg::VALUE_W-1:0]   opinion_i,
  input  logic                          first_of_set_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [clc_pkg::INDEX_W-1:0]   group_index_o,
  output logic                          new_group_o,
  output logic [clc_pkg::COUNT_W-1:0]   group_count_o,
  output logic                          overflow_o
);
  import clc_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_LEADERS);
  localparam int unsigned CntW = $clog2(NUM_LEADERS + 1);

  logic               circular_mode_q;
  logic [RES_W-1:0]   resolution_q;
  logic [CntW-1:0]    groups_used_q;
  logic               busy_q;
  logic               done_valid_q;
  logic [INDEX_W-1:0] done_idx_q;
  logic               done_created_q;
  logic [COUNT_W-1:0] done_cnt_q;
  logic               done_ovf_q;
  logic               out_valid_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic               out_created_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic               out_ovf_q;

  tok_t               tok_w [NUM_LEADERS+1];
  logic [IdxW-1:0]    idx_w [NUM_LEADERS+1];
  logic [CntW-1:0]    cnt_w [NUM_LEADERS+1];

  logic                    cfg_we;
  logic                    in_accept;
  logic                    out_load;
  logic                    end_valid;
  logic [IdxW+INDEX_W-1:0] idx_ext;
  logic [CntW+COUNT_W-1:0] cnt_ext;

  assign pready    = 1'b1;
  assign cfg_we    = psel & penable & pwrite & pready;
  assign in_accept = in_valid_i & ~busy_q;
  assign in_stall_o = busy_q;

  always_comb begin
    unique case (paddr[2])
      REG_MODE: prdata = {{(DATA_W-1){1'b0}}, circular_mode_q};
      REG_RES:  prdata = {{(DATA_W-RES_W){1'b0}}, resolution_q};
      default:  prdata = '0;
    endcase
  end

  assign tok_w[0] = '{valid: in_accept, value: opinion_i, found: 1'b0, created: 1'b0};
  assign idx_w[0] = '0;
  assign cnt_w[0] = first_of_set_i ? '0 : groups_used_q;

  for (genvar k = 0; k < NUM_LEADERS; k++) begin : g_cell
    clc_cell #(
      .CELL_IDX (k),
      .IDX_W    (IdxW),
      .CNT_W    (CntW)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .circular_mode_i (circular_mode_q),
      .resolution_i    (resolution_q),
      .tok_i           (tok_w[k]),
      .idx_i           (idx_w[k]),
      .cnt_i           (cnt_w[k]),
      .tok_o           (tok_w[k+1]),
      .idx_o           (idx_w[k+1]),
      .cnt_o           (cnt_w[k+1])
    );
  end

  assign end_valid = tok_w[NUM_LEADERS].valid;
  assign idx_ext   = {{INDEX_W{1'b0}}, idx_w[NUM_LEADERS]};
  assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_w[NUM_LEADERS]};
  assign out_load  = done_valid_q & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circular_mode_q <= MODE_RESET;
      resolution_q    <= RES_RESET;
      groups_used_q   <= '0;
      busy_q          <= 1'b0;
      done_valid_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (paddr[2])
          REG_MODE: circular_mode_q <= pwdata[0];
          REG_RES:  resolution_q    <= pwdata[RES_W-1:0];
          default:  circular_mode_q <= circular_mode_q;
        endcase
      end
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (end_valid) begin
        done_valid_q  <= 1'b1;
        groups_used_q <= cnt_w[NUM_LEADERS];
      end else if (out_load) begin
        done_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_valid) begin
      done_idx_q     <= idx_ext[INDEX_W-1:0];
      done_created_q <= tok_w[NUM_LEADERS].created;
      done_cnt_q     <= cnt_ext[COUNT_W-1:0];
      done_ovf_q     <= ~tok_w[NUM_LEADERS].found;
    end
    if (out_load) begin
      out_idx_q     <= done_idx_q;
      out_created_q <= done_created_q;
      out_cnt_q     <= done_cnt_q;
      out_ovf_q     <= done_ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign group_index_o = out_idx_q;
  assign new_group_o   = out_created_q;
  assign group_count_o = out_cnt_q;
  assign overflow_o    = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    groups_used_q <= CntW'(NUM_LEADERS))
    else $error("group count beyond table size");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_valid_q |-> busy_q)
    else $error("finished request without a request in flight");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_valid |-> (busy_q && !done_valid_q))
    else $error("chain delivered a request while another was pending");

  a_ovf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (!new_group_o && group_index_o == '0))
    else $error("overflow result carries a group");

  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_valid_q && done_created_q) |-> (groups_used_q != '0))
    else $error("new group without a group count");

endmodule
